// File: src/efr_pkg.sv
// Shared types and constants for the escaped frame responder.
package efr_pkg;

   localparam int MAX_STORED = 60;
   localparam int CMD_DEPTH  = 2;
   localparam int CMD_PTR_W  = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
   localparam int CMD_CNT_W  = $clog2(CMD_DEPTH + 1);
   localparam int CSR_IDX_W  = 4;

   localparam logic [7:0] BYTE_STX = 8'h02;
   localparam logic [7:0] BYTE_ETX = 8'h03;
   localparam logic [7:0] BYTE_ESC = 8'h08;
   localparam logic [7:0] ESC_OFFSET = 8'h09;

   localparam logic [CSR_IDX_W-1:0] CSR_OWN_ID        = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_RESPONSE_MODE = CSR_IDX_W'(1);

   localparam logic [1:0] MODE_ACK = 2'd0;
   localparam logic [1:0] MODE_NAK = 2'd1;

   localparam logic [1:0] KIND_NONE   = 2'd0;
   localparam logic [1:0] KIND_ACK    = 2'd1;
   localparam logic [1:0] KIND_NAK    = 2'd2;
   localparam logic [1:0] KIND_STATUS = 2'd3;

   typedef struct packed {
      logic [7:0] sender;
      logic [7:0] own;
      logic [1:0] kind;
   } cmd_type;

endpackage

// File: src/escaped_frame_responder_core.sv
// Top level of the escaped frame responder: registers, parser, command queue, serialiser.
//
//   channel   direction  handshake                 payload
//   req       in         push / full               req_rx_byte[7:0]
//   rsp       out        empty / pop               rsp_tx_byte[7:0], rsp_last_of_frame
//   csr       in         csr_valid / csr_ready     csr_index[3:0], csr_data[7:0]
//
// A byte is taken per cycle unless full; the parser judges a frame in the cycle its ETX arrives.
// Each reply is 21 or 22 beats, one per cycle from the step counter while pop keeps up.
// Up to two replies wait in the command queue; full rises only while it holds both.
// Reset is synchronous: registers return to own_id 137, response_mode 0, store empty.
// A stalled pop holds the output beat in its register; the parser runs on regardless.
module escaped_frame_responder_core
   import efr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  logic [7:0]           req_rx_byte,
   output logic                 empty,
   input  logic                 pop,
   output logic [7:0]           rsp_tx_byte,
   output logic                 rsp_last_of_frame,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_data
);

   logic [7:0] own_id_ff, own_id_in;
   logic [1:0] mode_ff, mode_in;
   logic       accept, cmd_valid, q_empty, q_full, q_pop;
   cmd_type    cmd, head;

   assign csr_ready = 1'b1;
   assign accept    = push && !q_full;
   assign full      = q_full;

   always_comb begin
      own_id_in = own_id_ff;
      mode_in   = mode_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_OWN_ID:        own_id_in = csr_data;
            CSR_RESPONSE_MODE: mode_in   = csr_data[1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_id_ff <= 8'd137;
         mode_ff   <= MODE_ACK;
      end else begin
         own_id_ff <= own_id_in;
         mode_ff   <= mode_in;
      end
   end

   efr_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .rx_byte       (req_rx_byte),
      .own_id        (own_id_ff),
      .response_mode (mode_ff),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd)
   );

   efr_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (cmd_valid),
      .wr_data (cmd),
      .rd_en   (q_pop),
      .rd_data (head),
      .q_empty (q_empty),
      .q_full  (q_full)
   );

   efr_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .head          (head),
      .q_pop         (q_pop),
      .pop           (pop),
      .empty         (empty),
      .tx_byte       (rsp_tx_byte),
      .last_of_frame (rsp_last_of_frame)
   );

endmodule

// File: src/efr_front.sv
// Receive parser: unescapes bytes, keeps header and checksum state, judges frames at ETX.
module efr_front
   import efr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] rx_byte,
   input  logic [7:0] own_id,
   input  logic [1:0] response_mode,
   output logic       cmd_valid,
   output cmd_type    cmd
);

   logic        esc_ff, esc_in;
   logic [5:0]  count_ff, count_in;
   logic [7:0]  addr_ff, addr_in;
   logic [7:0]  sender_ff, sender_in;
   logic [7:0]  code_ff, code_in;
   logic [7:0]  len_ff, len_in;
   logic [7:0]  req_ff, req_in;
   logic [15:0] sum_ff, sum_in;
   logic [7:0]  d0_ff, d0_in;
   logic [7:0]  d1_ff, d1_in;

   logic        clr, is_stx, is_etx, is_esc;
   logic [5:0]  count_e, pos, len_now;
   logic [15:0] sum_e, sum_base;
   logic [7:0]  d0_e, d1_e, d0_base, d1_base, stored_b;
   logic        frame_ok;
   logic [1:0]  kind;

   always_comb begin
      clr     = (count_ff >= 6'(MAX_STORED));
      count_e = clr ? 6'd0 : count_ff;
      sum_e   = clr ? 16'd0 : sum_ff;
      d0_e    = clr ? 8'd0 : d0_ff;
      d1_e    = clr ? 8'd0 : d1_ff;

      is_stx = (rx_byte == BYTE_STX);
      is_etx = (rx_byte == BYTE_ETX);
      is_esc = (rx_byte == BYTE_ESC);

      stored_b = (esc_ff && !is_stx && !is_etx) ? rx_byte - ESC_OFFSET : rx_byte;

      // STX restarts the store from position zero
      pos      = is_stx ? 6'd0 : count_e;
      sum_base = is_stx ? 16'd0 : sum_e;
      d0_base  = is_stx ? 8'd0 : d0_e;
      d1_base  = is_stx ? 8'd0 : d1_e;

      addr_in   = addr_ff;
      sender_in = sender_ff;
      code_in   = code_ff;
      len_in    = len_ff;
      req_in    = req_ff;
      esc_in    = esc_ff;
      count_in  = count_ff;
      sum_in    = sum_ff;
      d0_in     = d0_ff;
      d1_in     = d1_ff;

      len_now = pos + 6'd1;

      if (accept) begin
         esc_in = is_esc;
         if (is_esc) begin
            // escape marker is not stored, but the store-full clear still applies
            count_in = count_e;
            sum_in   = sum_e;
            d0_in    = d0_e;
            d1_in    = d1_e;
         end else begin
            unique case (pos)
               6'd1:    addr_in   = stored_b;
               6'd2:    sender_in = stored_b;
               6'd3:    code_in   = stored_b;
               6'd4:    len_in    = stored_b;
               6'd6:    req_in    = stored_b;
               default: ;
            endcase
            count_in = len_now;
            sum_in   = (pos >= 6'd4) ? sum_base + {8'd0, d1_base} : sum_base;
            d1_in    = d0_base;
            d0_in    = stored_b;
         end
      end

      // received checksum sits in the two delayed bytes, high byte newest
      frame_ok = (len_now >= 6'd8) && (addr_in == own_id)
               && (len_in == ({2'b00, len_now} - 8'd8))
               && (sum_base == {d0_base, d1_base});

      kind = KIND_NONE;
      if (code_in == 8'h0A) begin
         if (req_in == 8'h81) kind = KIND_STATUS;
      end else if (response_mode == MODE_ACK) begin
         kind = KIND_ACK;
      end else if (response_mode == MODE_NAK) begin
         kind = KIND_NAK;
      end

      cmd_valid  = accept && is_etx && frame_ok && (kind != KIND_NONE);
      cmd.sender = sender_in;
      cmd.own    = own_id;
      cmd.kind   = kind;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_ff    <= 1'b0;
         count_ff  <= 6'd0;
         addr_ff   <= 8'd0;
         sender_ff <= 8'd0;
         code_ff   <= 8'd0;
         len_ff    <= 8'd0;
         req_ff    <= 8'd0;
         sum_ff    <= 16'd0;
         d0_ff     <= 8'd0;
         d1_ff     <= 8'd0;
      end else begin
         esc_ff    <= esc_in;
         count_ff  <= count_in;
         addr_ff   <= addr_in;
         sender_ff <= sender_in;
         code_ff   <= code_in;
         len_ff    <= len_in;
         req_ff    <= req_in;
         sum_ff    <= sum_in;
         d0_ff     <= d0_in;
         d1_ff     <= d1_in;
      end
   end

endmodule

// File: src/efr_queue.sv
// Short queue of pending reply commands between parser and serialiser.
module efr_queue
   import efr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_en,
   input  cmd_type wr_data,
   input  logic    rd_en,
   output cmd_type rd_data,
   output logic    q_empty,
   output logic    q_full
);

   cmd_type                entry_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMD_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                   do_wr, do_rd;

   localparam logic [CMD_PTR_W-1:0] PTR_LAST = CMD_PTR_W'(CMD_DEPTH - 1);

   always_comb begin
      q_empty = (cnt_ff == '0);
      q_full  = (cnt_ff == CMD_CNT_W'(CMD_DEPTH));
      do_wr   = wr_en && !q_full;
      do_rd   = rd_en && !q_empty;
      rd_data = entry_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_wr) wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      if (do_rd) rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;

      cnt_in = cnt_ff;
      if (do_wr && !do_rd) cnt_in = cnt_ff + 1'b1;
      else if (do_rd && !do_wr) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_wr) entry_ff[wr_ptr_ff] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

// File: src/efr_back.sv
// Reply serialiser: walks the reply frame byte by byte into a one-beat output register.
module efr_back
   import efr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       q_empty,
   input  cmd_type    head,
   output logic       q_pop,
   input  logic       pop,
   output logic       empty,
   output logic [7:0] tx_byte,
   output logic       last_of_frame
);

   localparam logic [4:0] STEP_SUM_LO  = 5'd14;
   localparam logic [4:0] STEP_SUM_ESC = 5'd15;
   localparam logic [4:0] STEP_LAST    = 5'd21;

   logic [4:0] step_ff, step_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_last_ff, out_last_in;

   logic       advance, sum_esc;
   logic [7:0] code, sum, cur_byte;

   always_comb begin
      code    = {6'b010000, head.kind};
      sum     = head.own + 8'h0A + 8'h04 + 8'hA1 + code;
      sum_esc = (sum <= 8'h08);

      case (step_ff)
         5'd0, 5'd1, 5'd19: cur_byte = 8'hAA;
         5'd2:              cur_byte = 8'h02;
         5'd3:              cur_byte = head.sender;
         5'd4:              cur_byte = head.own;
         5'd5:              cur_byte = 8'h0A;
         5'd6, 5'd10, 5'd12, 5'd16: cur_byte = 8'h08;
         5'd7:              cur_byte = 8'h0D;
         5'd8:              cur_byte = 8'hA1;
         5'd9:              cur_byte = code;
         5'd11, 5'd13, 5'd17: cur_byte = 8'h09;
         5'd14:             cur_byte = sum_esc ? 8'h08 : sum;
         5'd15:             cur_byte = sum + 8'h09;
         5'd18:             cur_byte = 8'h03;
         5'd20:             cur_byte = 8'h55;
         default:           cur_byte = 8'h00;
      endcase

      advance = !q_empty && (!out_valid_ff || pop);
      q_pop   = advance && (step_ff == STEP_LAST);

      step_in = step_ff;
      if (advance) begin
         if (step_ff == STEP_LAST) step_in = 5'd0;
         else if (step_ff == STEP_SUM_LO && !sum_esc) step_in = STEP_SUM_ESC + 5'd1;
         else step_in = step_ff + 5'd1;
      end

      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_byte_in  = cur_byte;
         out_last_in  = (step_ff == STEP_LAST);
      end else if (pop) begin
         out_valid_in = 1'b0;
      end

      empty         = !out_valid_ff;
      tx_byte       = out_byte_ff;
      last_of_frame = out_last_ff;
   end

   always_ff @(posedge clock) begin
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
      if (reset) begin
         step_ff      <= 5'd0;
         out_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

// File: src/efr_checker.sv
// Port-level checks for the escaped frame responder, bound to the top level.
module efr_checker (
   input logic       clock,
   input logic       reset,
   input logic       full,
   input logic       empty,
   input logic       pop,
   input logic [7:0] rsp_tx_byte,
   input logic       rsp_last_of_frame
);

   // a beat left waiting stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_tx_byte) && $stable(rsp_last_of_frame)))
      else $error("rsp beat changed while stalled");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("queue not cleared by reset");

   // every reply closes on a zero byte
   a_last_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_last_of_frame) |-> (rsp_tx_byte == 8'h00))
      else $error("last beat of reply is not zero");

   // input is only refused while a reply is in hand
   a_full_busy: assert property (@(posedge clock) disable iff (reset)
      full |-> !empty)
      else $error("input refused with no reply pending");

endmodule

bind escaped_frame_responder_core efr_checker u_efr_checker (
   .clock             (clock),
   .reset             (reset),
   .full              (full),
   .empty             (empty),
   .pop               (pop),
   .rsp_tx_byte       (rsp_tx_byte),
   .rsp_last_of_frame (rsp_last_of_frame)
);

// File: sim/testbench.sv
// Self-checking testbench for the escaped frame responder: byte-level predictor and checker.
`timescale 1ns / 100ps

module testbench;
   import efr_pkg::*;

   localparam int HALF_PERIOD   = 10;
   localparam int RESET_CYCLES  = 8;
   localparam int SETTLE_CYCLES = 30;
   localparam int DRAIN_CYCLES  = 60;
   localparam int HOLD_CYCLES   = 400;
   localparam int STALL_LIMIT   = 4000;
   localparam int PHASE_BYTES   = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = CSR_IDX_W'(7);
   localparam logic [1:0] MODE_UNDEF = 2'd3;

   localparam logic [7:0] CMD_STATUS = 8'h0A;
   localparam logic [7:0] REQ_STATUS = 8'h81;
   localparam logic [7:0] CODE_ACK    = 8'h41;
   localparam logic [7:0] CODE_NAK    = 8'h42;
   localparam logic [7:0] CODE_STATUS = 8'h43;
   localparam logic [7:0] REPLY_LEN   = 8'h04;
   localparam logic [7:0] REPLY_TAG   = 8'hA1;
   localparam logic [7:0] PREAMBLE    = 8'hAA;
   localparam logic [7:0] TRAILER     = 8'h55;
   localparam logic [7:0] END_MARK    = 8'h00;
   localparam logic [7:0] MIN_FRAME   = 8'd8;

   localparam logic [5:0] POS_ADDR   = 6'd1;
   localparam logic [5:0] POS_SENDER = 6'd2;
   localparam logic [5:0] POS_CMD    = 6'd3;
   localparam logic [5:0] POS_LEN    = 6'd4;
   localparam logic [5:0] POS_REQ    = 6'd6;

   localparam int FLAW_NONE = 0;
   localparam int FLAW_SUM  = 1;
   localparam int FLAW_LEN  = 2;

   typedef struct {
      logic [7:0] tx;
      logic       last;
   } beat_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 push = 1'b0;
   logic                 full;
   logic [7:0]           req_rx_byte = 8'h00;
   logic                 empty;
   logic                 pop = 1'b0;
   logic [7:0]           rsp_tx_byte;
   logic                 rsp_last_of_frame;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [7:0]           csr_data = 8'h00;

   escaped_frame_responder_core uut (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_rx_byte       (req_rx_byte),
      .empty             (empty),
      .pop               (pop),
      .rsp_tx_byte       (rsp_tx_byte),
      .rsp_last_of_frame (rsp_last_of_frame),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // predictor state
   logic        escape_armed;
   logic [5:0]  stored;
   logic [7:0]  frame_addr, frame_sender, frame_cmd, frame_len, frame_req;
   logic [15:0] rx_sum;
   logic [7:0]  sum_pipe [2];
   logic [7:0]  own_id;
   logic [1:0]  resp_mode;

   beat_type   reply_beats [$];
   logic [7:0] frame_bytes [$];

   int mismatches    = 0;
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_requests = 0;
   int holds_taken   = 0;
   int hold_left     = 0;
   int bytes_sent    = 0;
   int quiet_cycles  = 0;

   task automatic flag_error(input string what);
      mismatches++;
      if (mismatches <= 10) $display("%0t: %s", $time, what);
   endtask

   task automatic clear_store();
      stored = '0;
      rx_sum = '0;
      sum_pipe[0] = '0;
      sum_pipe[1] = '0;
   endtask

   task automatic reset_model();
      own_id = 8'd137;
      resp_mode = MODE_ACK;
      escape_armed = 1'b0;
      clear_store();
      frame_addr = '0;
      frame_sender = '0;
      frame_cmd = '0;
      frame_len = '0;
      frame_req = '0;
   endtask

   function automatic logic [5:0] store_byte(input logic [7:0] b);
      logic [5:0] pos;
      pos = stored;
      case (pos)
         POS_ADDR:   frame_addr = b;
         POS_SENDER: frame_sender = b;
         POS_CMD:    frame_cmd = b;
         POS_LEN:    frame_len = b;
         POS_REQ:    frame_req = b;
         default: ;
      endcase
      stored = pos + 6'd1;
      return pos;
   endfunction

   // the sum trails by two bytes so the received checksum word stays out of it
   task automatic shift_sum(input logic [7:0] b, input logic [5:0] pos);
      if (pos >= POS_LEN) rx_sum = rx_sum + {8'h00, sum_pipe[1]};
      sum_pipe[1] = sum_pipe[0];
      sum_pipe[0] = b;
   endtask

   task automatic add_beat(input logic [7:0] b, input logic last);
      beat_type item;
      item.tx = b;
      item.last = last;
      reply_beats.push_back(item);
   endtask

   task automatic add_stuffed(input logic [7:0] b);
      if (b <= BYTE_ESC) begin
         add_beat(BYTE_ESC, 1'b0);
         add_beat(b + ESC_OFFSET, 1'b0);
      end else begin
         add_beat(b, 1'b0);
      end
   endtask

   task automatic queue_reply(input logic [7:0] code);
      logic [7:0] csum;
      csum = own_id + CMD_STATUS + REPLY_LEN + REPLY_TAG + code;
      add_beat(PREAMBLE, 1'b0);
      add_beat(PREAMBLE, 1'b0);
      add_beat(BYTE_STX, 1'b0);
      // header addresses go out raw
      add_beat(frame_sender, 1'b0);
      add_beat(own_id, 1'b0);
      add_beat(CMD_STATUS, 1'b0);
      add_stuffed(REPLY_LEN);
      add_beat(REPLY_TAG, 1'b0);
      add_beat(code, 1'b0);
      add_stuffed(8'h00);
      add_stuffed(8'h00);
      add_stuffed(csum);
      add_stuffed(8'h00);
      add_beat(BYTE_ETX, 1'b0);
      add_beat(PREAMBLE, 1'b0);
      add_beat(TRAILER, 1'b0);
      add_beat(END_MARK, 1'b1);
   endtask

   task automatic judge_frame();
      logic [1:0] kind;
      kind = KIND_NONE;
      if ({2'b00, stored} >= MIN_FRAME && frame_addr == own_id &&
          frame_len == ({2'b00, stored} - MIN_FRAME) && rx_sum == {sum_pipe[0], sum_pipe[1]}) begin
         if (frame_cmd == CMD_STATUS) begin
            if (frame_req == REQ_STATUS) kind = KIND_STATUS;
         end else if (resp_mode == MODE_ACK) begin
            kind = KIND_ACK;
         end else if (resp_mode == MODE_NAK) begin
            kind = KIND_NAK;
         end
      end
      case (kind)
         KIND_ACK:    queue_reply(CODE_ACK);
         KIND_NAK:    queue_reply(CODE_NAK);
         KIND_STATUS: queue_reply(CODE_STATUS);
         default: ;
      endcase
   endtask

   task automatic parse_rx_byte(input logic [7:0] raw);
      logic [7:0] data_byte;
      logic [5:0] pos;
      data_byte = raw;
      if (stored >= MAX_STORED) clear_store();
      if (data_byte == BYTE_STX) begin
         clear_store();
         escape_armed = 1'b0;
         pos = store_byte(data_byte);
         shift_sum(data_byte, pos);
      end else if (data_byte == BYTE_ETX) begin
         pos = store_byte(data_byte);
         judge_frame();
         shift_sum(data_byte, pos);
         escape_armed = 1'b0;
      end else if (data_byte == BYTE_ESC) begin
         escape_armed = 1'b1;
      end else begin
         if (escape_armed) begin
            data_byte = data_byte - ESC_OFFSET;
            escape_armed = 1'b0;
         end
         pos = store_byte(data_byte);
         shift_sum(data_byte, pos);
      end
   endtask

   task automatic send_byte(input logic [7:0] b);
      req_rx_byte <= b;
      push <= 1'b1;
      do @(posedge clock); while (full);
      parse_rx_byte(b);
      bytes_sent++;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic send_frame();
      foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
   endtask

   // hold until every reply has drained and the parser has settled
   task automatic wait_idle();
      push <= 1'b0;
      while (reply_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [7:0] data);
      csr_index <= idx;
      csr_data <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_OWN_ID:        own_id = data;
         CSR_RESPONSE_MODE: resp_mode = data[1:0];
         default: ;
      endcase
   endtask

   // escape control bytes always, others now and then where the lifted value is safe
   function automatic void put_stored(input logic [7:0] b);
      logic [7:0] lifted;
      lifted = b + ESC_OFFSET;
      if (b == BYTE_STX || b == BYTE_ETX || b == BYTE_ESC ||
          (lifted != BYTE_STX && lifted != BYTE_ETX && lifted != BYTE_ESC &&
           $urandom_range(0, 9) == 0)) begin
         frame_bytes.push_back(BYTE_ESC);
         frame_bytes.push_back(lifted);
      end else begin
         frame_bytes.push_back(b);
      end
   endfunction

   task automatic build_frame(input logic [7:0] addr, input logic [7:0] sender,
                              input logic [7:0] cmd, input logic [7:0] req,
                              input int nb, input int flaw);
      logic [7:0]  body [$];
      logic [15:0] word;
      body.push_back(sender);
      body.push_back(cmd);
      body.push_back(8'(nb - 3));
      for (int i = 3; i < nb; i++) body.push_back(i == 4 ? req : 8'($urandom_range(0, 255)));
      if (flaw == FLAW_LEN) body[2] = body[2] + 8'($urandom_range(1, 255));
      word = '0;
      foreach (body[i]) word = word + {8'h00, body[i]};
      if (flaw == FLAW_SUM) word = word ^ 16'($urandom_range(1, 65535));
      frame_bytes.delete();
      frame_bytes.push_back(BYTE_STX);
      put_stored(addr);
      foreach (body[i]) put_stored(body[i]);
      put_stored(word[7:0]);
      put_stored(word[15:8]);
      frame_bytes.push_back(BYTE_ETX);
   endtask

   task automatic send_random_frame();
      int         pick, nb, flaw, roll;
      logic [7:0] addr, cmd, req;
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
         nb = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 55) : $urandom_range(3, 10);
         if (pick >= 73) nb = $urandom_range(56, 66);   // runs past the store limit
         addr = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : own_id;
         cmd = ($urandom_range(0, 2) == 0) ? CMD_STATUS : 8'($urandom_range(0, 255));
         req = ($urandom_range(0, 2) != 0) ? REQ_STATUS : 8'($urandom_range(0, 255));
         roll = $urandom_range(0, 9);
         flaw = (roll == 0) ? FLAW_SUM : ((roll == 1) ? FLAW_LEN : FLAW_NONE);
         build_frame(addr, 8'($urandom_range(0, 255)), cmd, req, nb, flaw);
      end else begin
         frame_bytes.delete();
         repeat ($urandom_range(1, 8)) begin
            case ($urandom_range(0, 5))
               0: frame_bytes.push_back(BYTE_STX);
               1: frame_bytes.push_back(BYTE_ETX);
               2: frame_bytes.push_back(BYTE_ESC);
               default: frame_bytes.push_back(8'($urandom_range(0, 255)));
            endcase
         end
      end
      send_frame();
   endtask

   task automatic test_frame_kinds();
      // shortest frame gets an ack, then a status request, then a silent command
      build_frame(own_id, 8'h00, 8'hFF, 8'h00, 3, FLAW_NONE);
      send_frame();
      build_frame(own_id, 8'hFF, CMD_STATUS, REQ_STATUS, 5, FLAW_NONE);
      send_frame();
      build_frame(own_id, 8'h5A, CMD_STATUS, 8'h7E, 5, FLAW_NONE);
      send_frame();
   endtask

   task automatic test_escapes();
      // a doubled escape stays armed and STX drops it
      send_byte(BYTE_ESC);
      send_byte(BYTE_ESC);
      build_frame(own_id, BYTE_STX, BYTE_ETX, BYTE_ESC, 4, FLAW_NONE);
      send_frame();
      // escape in front of ETX: ETX still ends the frame
      send_byte(BYTE_ESC);
      send_byte(BYTE_ETX);
   endtask

   task automatic test_mode_three();
      wait_idle();
      write_reg(CSR_RESPONSE_MODE, {6'd0, MODE_UNDEF});
      write_reg(CSR_SPARE, 8'hFF);
      build_frame(own_id, 8'h33, 8'h20, 8'h00, 3, FLAW_NONE);
      send_frame();
      build_frame(own_id, 8'h44, CMD_STATUS, REQ_STATUS, 6, FLAW_NONE);
      send_frame();
   endtask

   task automatic test_random_phases();
      logic [7:0] own_vals [4];
      logic [7:0] mode_vals [4];
      int         send_vals [4];
      int         stall_vals [4];
      int         target;
      own_vals   = '{8'hFF, 8'h09, 8'h12, 8'h00};
      mode_vals  = '{8'hFC, {6'd0, MODE_NAK}, 8'h06, {6'd0, MODE_ACK}};
      send_vals  = '{0, 75, 0, 12};
      stall_vals = '{0, 0, 75, 12};
      for (int p = 0; p < 4; p++) begin
         wait_idle();
         write_reg(CSR_OWN_ID, own_vals[p]);
         write_reg(CSR_RESPONSE_MODE, mode_vals[p]);
         send_idle_pct = send_vals[p];
         stall_pct = stall_vals[p];
         target = bytes_sent + PHASE_BYTES;
         while (bytes_sent < target) send_random_frame();
      end
   endtask

   task automatic test_backpressure();
      wait_idle();
      write_reg(CSR_OWN_ID, 8'h12);
      write_reg(CSR_RESPONSE_MODE, {6'd0, MODE_ACK});
      send_idle_pct = 0;
      stall_pct = 0;
      hold_requests++;
      repeat (3) begin
         build_frame(own_id, 8'($urandom_range(0, 255)), 8'($urandom_range(8'h0B, 8'hFF)),
                     8'($urandom_range(0, 255)), $urandom_range(3, 6), FLAW_NONE);
         send_frame();
      end
   endtask

   task automatic check_beat();
      beat_type want;
      if (reply_beats.size() == 0) begin
         flag_error($sformatf("unexpected beat tx_byte %h last %b",
                              rsp_tx_byte, rsp_last_of_frame));
      end else begin
         want = reply_beats.pop_front();
         if (rsp_tx_byte !== want.tx)
            flag_error($sformatf("tx_byte expected %h got %h", want.tx, rsp_tx_byte));
         if (rsp_last_of_frame !== want.last)
            flag_error($sformatf("last_of_frame expected %b got %b (tx_byte %h)",
                                 want.last, rsp_last_of_frame, want.tx));
      end
   endtask

   // receiver: check each beat, stall at random, take long hold-offs on request
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) check_beat();
         if (hold_requests != holds_taken) begin
            holds_taken = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
         end else begin
            pop <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if ((push && !full) || (pop && !empty) || (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL escaped_frame_responder_core");
            $finish;
         end
      end
   end

   initial begin
      reset_model();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_frame_kinds();
      test_escapes();
      test_mode_three();
      test_random_phases();
      test_backpressure();
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && reply_beats.size() == 0) begin
         $display("PASS escaped_frame_responder_core");
      end else begin
         $display("FAIL escaped_frame_responder_core");
      end
      $finish;
   end

endmodule
